// ===== design/bup_pkg.sv =====
package bup_pkg;

  // Default sizes of the block.
  localparam int IN_SIZE_DEF     = 16;
  localparam int OUT_SIZE_DEF    = 128;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed port widths.
  localparam int OP_W      = 1;
  localparam int SRC_IDX_W = 4;
  localparam int SAMPLE_W  = 12;
  localparam int OUT_IDX_W = 7;
  localparam int PIX_W     = 12;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_RD,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_ROUND,
    ST_DIV_SUM,
    ST_DIV_OUT
  } state_t;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_T_LOAD,
    MAC_T_ADD,
    MAC_ACC_LOAD,
    MAC_ACC_ADD
  } mac_op_t;

  typedef enum logic [1:0] {
    W_ROW_LO,
    W_ROW_HI,
    W_COL_LO,
    W_COL_HI
  } wsel_t;

  typedef struct packed {
    mac_op_t op;
    wsel_t   wsel;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    NB_R1C1,
    NB_R2C1,
    NB_R1C2,
    NB_R2C2
  } nbr_t;

endpackage

// ===== design/bup_store.sv =====
module bup_store #(
  parameter int IN_SIZE     = bup_pkg::IN_SIZE_DEF,
  parameter int SAMPLE_BITS = bup_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(IN_SIZE*IN_SIZE)-1:0]   waddr,
  input  logic [SAMPLE_BITS-1:0]               wdata,
  input  logic                                 re,
  input  logic [$clog2(IN_SIZE*IN_SIZE)-1:0]   raddr,
  output logic [SAMPLE_BITS-1:0]               rdata
);

  localparam int DEPTH = IN_SIZE * IN_SIZE;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bup_div.sv =====
module bup_div #(
  parameter int IN_SIZE     = bup_pkg::IN_SIZE_DEF,
  parameter int OUT_SIZE    = bup_pkg::OUT_SIZE_DEF,
  parameter int SAMPLE_BITS = bup_pkg::SAMPLE_BITS_DEF,
  localparam int IB = $clog2(IN_SIZE),
  localparam int FB = $clog2(OUT_SIZE),
  localparam int SB = SAMPLE_BITS,
  localparam int XW = (SB + 2 * FB > FB + IB) ? SB + 2 * FB : FB + IB,
  localparam int QW = XW - FB + 1
) (
  input  logic          clk,
  input  logic          load,
  input  logic [XW-1:0] dividend,
  output logic [QW-1:0] quo,
  output logic [FB-1:0] rem
);

  localparam int DEN = OUT_SIZE - 1;
  localparam int SH  = XW + FB;
  localparam int SW  = SH + 1;
  localparam int MW  = XW + 2;
  localparam int PRW = XW + MW;

  // Rounded-up reciprocal of DEN. With a shift of XW + FB bits the
  // quotient is exact for every dividend that fits in XW bits.
  localparam logic [SW-1:0] ONE_SH = SW'(1) << SH;
  localparam logic [MW-1:0] RECIP  = MW'((ONE_SH + SW'(DEN - 1)) / SW'(DEN));

  logic [XW-1:0]  x_r;
  logic [QW-1:0]  q_r;
  logic [PRW-1:0] prod;
  logic [XW-1:0]  back;

  assign prod = PRW'(dividend) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= dividend;
      q_r <= prod[SH +: QW];
    end
  end

  // The remainder comes from the registered quotient in the next cycle.
  assign back = XW'(q_r) * XW'(DEN);
  assign quo  = q_r;
  assign rem  = FB'(x_r - back);

endmodule

// ===== design/bup_mac.sv =====
module bup_mac #(
  parameter int OUT_SIZE    = bup_pkg::OUT_SIZE_DEF,
  parameter int SAMPLE_BITS = bup_pkg::SAMPLE_BITS_DEF,
  localparam int FB = $clog2(OUT_SIZE),
  localparam int SB = SAMPLE_BITS,
  localparam int PW = SB + 2 * FB
) (
  input  logic              clk,
  input  bup_pkg::mac_ctl_t ctl,
  input  logic [SB-1:0]     sample,
  input  logic [FB-1:0]     row_lo_w,
  input  logic [FB-1:0]     row_hi_w,
  input  logic [FB-1:0]     col_lo_w,
  input  logic [FB-1:0]     col_hi_w,
  output logic [PW-1:0]     acc
);

  localparam int TW = SB + FB;

  logic [TW-1:0] t_r, t_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [TW-1:0] a;
  logic [FB-1:0] b;
  logic [PW-1:0] prod;

  // The partial row blend t holds one column's two weighted samples;
  // it is then scaled by the column weight into the accumulator.
  always_comb begin
    case (ctl.wsel)
      bup_pkg::W_ROW_LO: b = row_lo_w;
      bup_pkg::W_ROW_HI: b = row_hi_w;
      bup_pkg::W_COL_LO: b = col_lo_w;
      bup_pkg::W_COL_HI: b = col_hi_w;
      default:           b = '0;
    endcase
    if (ctl.op == bup_pkg::MAC_ACC_LOAD || ctl.op == bup_pkg::MAC_ACC_ADD) begin
      a = t_r;
    end else begin
      a = TW'(sample);
    end
    prod    = PW'(a) * PW'(b);
    t_nxt   = t_r;
    acc_nxt = acc_r;
    case (ctl.op)
      bup_pkg::MAC_T_LOAD:   t_nxt   = prod[TW-1:0];
      bup_pkg::MAC_T_ADD:    t_nxt   = t_r + prod[TW-1:0];
      bup_pkg::MAC_ACC_LOAD: acc_nxt = prod;
      bup_pkg::MAC_ACC_ADD:  acc_nxt = acc_r + prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== design/bilinear_upscale_16_to_128_top.sv =====
// Channel   Ports                                                          Handshake
// input     in_operation in_src_row in_src_col in_sample in_out_row in_out_col  start, busy
// result    out_pixel_value                                          out_valid (strobe)
//
// A request is taken at a rising edge with start high and busy low.
// A load never raises busy. A query holds busy high through its states:
// DIV_ROW and DIV_COL map the row and column through the shared reciprocal
// divider, RD primes the first sample read, M0 to M5 pass through the shared
// multiplier, ROUND adds the rounding offset and DIV_SUM and DIV_OUT divide
// the sum by OUT_SIZE-1 twice. Its result strobes on out_valid in the first
// cycle with busy low again. Reset is synchronous, active low, and clears the
// control state only. The receiver cannot stall the block.
module bilinear_upscale_16_to_128_top #(
  parameter int IN_SIZE     = bup_pkg::IN_SIZE_DEF,
  parameter int OUT_SIZE    = bup_pkg::OUT_SIZE_DEF,
  parameter int SAMPLE_BITS = bup_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bup_pkg::OP_W-1:0]      in_operation,
  input  logic [bup_pkg::SRC_IDX_W-1:0] in_src_row,
  input  logic [bup_pkg::SRC_IDX_W-1:0] in_src_col,
  input  logic [bup_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [bup_pkg::OUT_IDX_W-1:0] in_out_row,
  input  logic [bup_pkg::OUT_IDX_W-1:0] in_out_col,
  output logic                          out_valid,
  output logic [bup_pkg::PIX_W-1:0]     out_pixel_value
);

  localparam int IB     = $clog2(IN_SIZE);
  localparam int AW     = $clog2(IN_SIZE * IN_SIZE);
  localparam int FB     = $clog2(OUT_SIZE);
  localparam int SB     = SAMPLE_BITS;
  localparam int XW     = (SB + 2 * FB > FB + IB) ? SB + 2 * FB : FB + IB;
  localparam int QW     = XW - FB + 1;
  localparam int PW     = SB + 2 * FB;
  localparam int NUMW   = FB + IB;
  localparam int DEN    = OUT_SIZE - 1;
  localparam int D      = DEN * DEN;
  localparam int HALF_D = D / 2;
  localparam int SXW    = (SB > bup_pkg::SAMPLE_W) ? SB : bup_pkg::SAMPLE_W;
  localparam int PXW    = (SB > bup_pkg::PIX_W) ? SB : bup_pkg::PIX_W;
  localparam int IXW    = ((IB > bup_pkg::SRC_IDX_W) ? IB : bup_pkg::SRC_IDX_W) + 1;
  localparam int OXW    = ((FB > bup_pkg::OUT_IDX_W) ? FB : bup_pkg::OUT_IDX_W) + 1;

  bup_pkg::state_t   state_r, state_nxt;
  bup_pkg::mac_ctl_t mac_ctl;
  bup_pkg::nbr_t     nb_sel;

  logic accept;
  logic rd_en;
  logic cap_row;
  logic cap_col;
  logic res_valid;
  logic div_ld;

  // Load request decode.
  logic [IXW-1:0] src_row_x;
  logic [IXW-1:0] src_col_x;
  logic           src_in_grid;
  logic           store_we;
  logic [AW-1:0]  store_waddr;
  logic [SXW-1:0] sample_x;

  // Query request decode: coordinates saturate to the last output pixel.
  logic [OXW-1:0]  out_row_x;
  logic [OXW-1:0]  out_col_x;
  logic [FB-1:0]   o_row;
  logic [FB-1:0]   o_col;
  logic [FB-1:0]   o_col_r;
  logic [NUMW-1:0] num_row;
  logic [NUMW-1:0] num_col;

  // Source position of the pixel: integer part and remainder over DEN.
  logic [IB-1:0] lo_row_r, lo_col_r;
  logic [IB-1:0] hi_row, hi_col;
  logic [FB-1:0] frac_row_r, frac_col_r;
  logic [FB-1:0] row_lo_w, col_lo_w;

  logic [AW-1:0]  store_raddr;
  logic [SB-1:0]  store_rdata;
  logic [XW-1:0]  div_x;
  logic [QW-1:0]  div_quo;
  logic [FB-1:0]  div_rem;
  logic [PW-1:0]  mac_acc;
  logic [PXW-1:0] pix_x;

  logic                      out_valid_r, out_valid_nxt;
  logic [bup_pkg::PIX_W-1:0] out_pixel_value_r;

  assign busy   = (state_r != bup_pkg::ST_IDLE);
  assign accept = start && !busy;

  // A load outside the source grid is dropped.
  assign src_row_x   = IXW'(in_src_row);
  assign src_col_x   = IXW'(in_src_col);
  assign src_in_grid = (src_row_x < IXW'(IN_SIZE)) && (src_col_x < IXW'(IN_SIZE));
  assign store_we    = accept && (in_operation == bup_pkg::OP_LOAD) && src_in_grid;
  assign store_waddr = AW'(src_row_x[IB-1:0]) * AW'(IN_SIZE) + AW'(src_col_x[IB-1:0]);
  assign sample_x    = SXW'(in_sample);

  assign out_row_x = OXW'(in_out_row);
  assign out_col_x = OXW'(in_out_col);
  assign o_row = (out_row_x >= OXW'(DEN)) ? FB'(DEN) : out_row_x[FB-1:0];
  assign o_col = (out_col_x >= OXW'(DEN)) ? FB'(DEN) : out_col_x[FB-1:0];

  // Position numerator o * (IN_SIZE - 1); the divider splits it by DEN.
  assign num_row = NUMW'(o_row) * NUMW'(IN_SIZE - 1);
  assign num_col = NUMW'(o_col_r) * NUMW'(IN_SIZE - 1);

  // The upper neighbor stops at the last source row or column, where its
  // weight is zero anyway.
  assign hi_row   = (lo_row_r == IB'(IN_SIZE - 1)) ? lo_row_r : lo_row_r + 1'b1;
  assign hi_col   = (lo_col_r == IB'(IN_SIZE - 1)) ? lo_col_r : lo_col_r + 1'b1;
  assign row_lo_w = FB'(DEN) - frac_row_r;
  assign col_lo_w = FB'(DEN) - frac_col_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bup_pkg::ST_IDLE: begin
        if (accept && (in_operation == bup_pkg::OP_QUERY)) begin
          state_nxt = bup_pkg::ST_DIV_ROW;
        end
      end
      bup_pkg::ST_DIV_ROW: state_nxt = bup_pkg::ST_DIV_COL;
      bup_pkg::ST_DIV_COL: state_nxt = bup_pkg::ST_RD;
      bup_pkg::ST_RD:      state_nxt = bup_pkg::ST_M0;
      bup_pkg::ST_M0:      state_nxt = bup_pkg::ST_M1;
      bup_pkg::ST_M1:      state_nxt = bup_pkg::ST_M2;
      bup_pkg::ST_M2:      state_nxt = bup_pkg::ST_M3;
      bup_pkg::ST_M3:      state_nxt = bup_pkg::ST_M4;
      bup_pkg::ST_M4:      state_nxt = bup_pkg::ST_M5;
      bup_pkg::ST_M5:      state_nxt = bup_pkg::ST_ROUND;
      bup_pkg::ST_ROUND:   state_nxt = bup_pkg::ST_DIV_SUM;
      bup_pkg::ST_DIV_SUM: state_nxt = bup_pkg::ST_DIV_OUT;
      bup_pkg::ST_DIV_OUT: state_nxt = bup_pkg::ST_IDLE;
      default:             state_nxt = bup_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. The divider answers in the cycle after it is loaded.
  // The four samples are read one at a time; each column's two samples are
  // blended by the row weights into a partial sum, which is then scaled by
  // that column's weight and accumulated.
  always_comb begin
    div_ld    = 1'b0;
    div_x     = XW'(num_row);
    mac_ctl   = '{op: bup_pkg::MAC_NONE, wsel: bup_pkg::W_ROW_LO};
    rd_en     = 1'b0;
    nb_sel    = bup_pkg::NB_R1C1;
    cap_row   = 1'b0;
    cap_col   = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      bup_pkg::ST_IDLE: begin
        div_ld = accept && (in_operation == bup_pkg::OP_QUERY);
      end
      bup_pkg::ST_DIV_ROW: begin
        cap_row = 1'b1;
        div_ld  = 1'b1;
        div_x   = XW'(num_col);
      end
      bup_pkg::ST_DIV_COL: begin
        cap_col = 1'b1;
      end
      bup_pkg::ST_RD: begin
        rd_en  = 1'b1;
        nb_sel = bup_pkg::NB_R1C1;
      end
      bup_pkg::ST_M0: begin
        mac_ctl = '{op: bup_pkg::MAC_T_LOAD, wsel: bup_pkg::W_ROW_LO};
        rd_en   = 1'b1;
        nb_sel  = bup_pkg::NB_R2C1;
      end
      bup_pkg::ST_M1: begin
        mac_ctl = '{op: bup_pkg::MAC_T_ADD, wsel: bup_pkg::W_ROW_HI};
      end
      bup_pkg::ST_M2: begin
        mac_ctl = '{op: bup_pkg::MAC_ACC_LOAD, wsel: bup_pkg::W_COL_LO};
        rd_en   = 1'b1;
        nb_sel  = bup_pkg::NB_R1C2;
      end
      bup_pkg::ST_M3: begin
        mac_ctl = '{op: bup_pkg::MAC_T_LOAD, wsel: bup_pkg::W_ROW_LO};
        rd_en   = 1'b1;
        nb_sel  = bup_pkg::NB_R2C2;
      end
      bup_pkg::ST_M4: begin
        mac_ctl = '{op: bup_pkg::MAC_T_ADD, wsel: bup_pkg::W_ROW_HI};
      end
      bup_pkg::ST_M5: begin
        mac_ctl = '{op: bup_pkg::MAC_ACC_ADD, wsel: bup_pkg::W_COL_HI};
      end
      bup_pkg::ST_ROUND: begin
        // Round half up: floor((2 * sum + D) / (2 * D)) equals
        // floor((sum + floor(D / 2)) / D), taken as two divisions by DEN.
        div_ld = 1'b1;
        div_x  = XW'(mac_acc) + XW'(HALF_D);
      end
      bup_pkg::ST_DIV_SUM: begin
        div_ld = 1'b1;
        div_x  = XW'(div_quo);
      end
      bup_pkg::ST_DIV_OUT: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (nb_sel)
      bup_pkg::NB_R1C1: store_raddr = AW'(lo_row_r) * AW'(IN_SIZE) + AW'(lo_col_r);
      bup_pkg::NB_R2C1: store_raddr = AW'(hi_row) * AW'(IN_SIZE) + AW'(lo_col_r);
      bup_pkg::NB_R1C2: store_raddr = AW'(lo_row_r) * AW'(IN_SIZE) + AW'(hi_col);
      bup_pkg::NB_R2C2: store_raddr = AW'(hi_row) * AW'(IN_SIZE) + AW'(hi_col);
      default:          store_raddr = '0;
    endcase
  end

  assign pix_x         = PXW'(div_quo[SB-1:0]);
  assign out_valid_nxt = res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bup_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_col_r <= o_col;
    end
    if (cap_row) begin
      lo_row_r   <= div_quo[IB-1:0];
      frac_row_r <= div_rem;
    end
    if (cap_col) begin
      lo_col_r   <= div_quo[IB-1:0];
      frac_col_r <= div_rem;
    end
    if (res_valid) begin
      out_pixel_value_r <= pix_x[bup_pkg::PIX_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;

  bup_store #(
    .IN_SIZE     (IN_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (sample_x[SB-1:0]),
    .re    (rd_en),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  bup_div #(
    .IN_SIZE     (IN_SIZE),
    .OUT_SIZE    (OUT_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .load     (div_ld),
    .dividend (div_x),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  bup_mac #(
    .OUT_SIZE    (OUT_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .sample   (store_rdata),
    .row_lo_w (row_lo_w),
    .row_hi_w (frac_row_r),
    .col_lo_w (col_lo_w),
    .col_hi_w (frac_col_r),
    .acc      (mac_acc)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Keeps its own copy of the sample store and works out the expected pixel of each
// query the moment the block takes the request.
class upscale_scoreboard;
  bit [bup_pkg::PIX_W-1:0] samples [bup_pkg::IN_SIZE_DEF*bup_pkg::IN_SIZE_DEF];
  bit [bup_pkg::PIX_W-1:0] pending_pixels [$];
  int mismatches;

  // Splits an output index into lower source index, upper neighbour and the
  // remainder over (OUT_SIZE-1).
  static function void map_axis(input int unsigned pos, output int unsigned lo,
                                output int unsigned hi, output int unsigned frac);
    int unsigned num;
    int unsigned last_pos;
    int unsigned last_src;
    last_pos = bup_pkg::OUT_SIZE_DEF - 1;
    last_src = bup_pkg::IN_SIZE_DEF - 1;
    if (pos > last_pos) pos = last_pos;
    num  = pos * last_src;
    lo   = num / last_pos;
    frac = num % last_pos;
    if (lo > last_src) lo = last_src;
    hi = (lo + 1 > last_src) ? last_src : lo + 1;
  endfunction

  function void note_request(input logic [bup_pkg::OP_W-1:0] op,
                             input int unsigned src_row, input int unsigned src_col,
                             input int unsigned sample, input int unsigned out_row,
                             input int unsigned out_col);
    int unsigned rl, rh, rf, cl, ch, cf, steps;
    longint unsigned sum, den;
    longint unsigned pix;
    if (op == bup_pkg::OP_LOAD) begin
      if (src_row < bup_pkg::IN_SIZE_DEF && src_col < bup_pkg::IN_SIZE_DEF)
        samples[src_row*bup_pkg::IN_SIZE_DEF + src_col] = sample[bup_pkg::PIX_W-1:0];
    end else begin
      map_axis(out_row, rl, rh, rf);
      map_axis(out_col, cl, ch, cf);
      steps = bup_pkg::OUT_SIZE_DEF - 1;
      den = longint'(steps) * steps;
      sum = longint'(samples[rl*bup_pkg::IN_SIZE_DEF + cl]) * (steps - rf) * (steps - cf)
          + longint'(samples[rh*bup_pkg::IN_SIZE_DEF + cl]) * rf * (steps - cf)
          + longint'(samples[rl*bup_pkg::IN_SIZE_DEF + ch]) * (steps - rf) * cf
          + longint'(samples[rh*bup_pkg::IN_SIZE_DEF + ch]) * rf * cf;
      // Round half up; den is odd, so an exact tie cannot occur.
      pix = (2 * sum + den) / (2 * den);
      pending_pixels = {pending_pixels, pix[bup_pkg::PIX_W-1:0]};
    end
  endfunction

  function void check_result(input logic [bup_pkg::PIX_W-1:0] got);
    bit [bup_pkg::PIX_W-1:0] want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel result: actual %0d, no query outstanding", got);
    end else begin
      want = pending_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected %0d, actual %0d", want, got);
      end
    end
  endfunction
endclass

module testbench;

  localparam int SRC_N      = bup_pkg::IN_SIZE_DEF;
  localparam int PIX_N      = bup_pkg::OUT_SIZE_DEF;
  localparam int SAMPLE_MAX = (1 << bup_pkg::SAMPLE_W) - 1;
  // Ample for ~1600 requests, each query holding busy for its whole run, and
  // for the idle gaps between them, taken several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 1360;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [bup_pkg::OP_W-1:0]      in_operation;
  logic [bup_pkg::SRC_IDX_W-1:0] in_src_row;
  logic [bup_pkg::SRC_IDX_W-1:0] in_src_col;
  logic [bup_pkg::SAMPLE_W-1:0]  in_sample;
  logic [bup_pkg::OUT_IDX_W-1:0] in_out_row;
  logic [bup_pkg::OUT_IDX_W-1:0] in_out_col;
  logic                          out_valid;
  logic [bup_pkg::PIX_W-1:0]     out_pixel_value;

  upscale_scoreboard pixels;

  // Which store entries the stimulus has written so far. A query is only
  // issued once all four of its neighbours hold a sample.
  bit loaded [SRC_N*SRC_N];

  // Percentage of requests followed by an idle gap on the request side.
  int idle_pct;
  int cycles;

  bilinear_upscale_16_to_128_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_src_row      (in_src_row),
    .in_src_col      (in_src_col),
    .in_sample       (in_sample),
    .in_out_row      (in_out_row),
    .in_out_col      (in_out_col),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Results are sampled at the rising edge; the strobe lasts exactly one
  // cycle and cannot be held off, so every strobe is one result.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      pixels.check_result(out_pixel_value);
  end

  // Sample values lean toward the extremes so that full-scale blends and
  // all-zero blends both show up, while uniform draws cover every bit.
  function automatic int unsigned pick_sample();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 0;
    if (roll == 1) return SAMPLE_MAX;
    return $urandom_range(SAMPLE_MAX);
  endfunction

  // Presents one request at the falling edge and holds it until a rising
  // edge sees start high with busy low. The fields a request does not use
  // carry random values so the block has to ignore them. Returns at a
  // falling edge, after an optional idle gap.
  task automatic send_request(input logic [bup_pkg::OP_W-1:0] op,
                              input int unsigned src_row,
                              input int unsigned src_col, input int unsigned sample,
                              input int unsigned out_row, input int unsigned out_col);
    start        = 1'b1;
    in_operation = op;
    in_src_row   = src_row[bup_pkg::SRC_IDX_W-1:0];
    in_src_col   = src_col[bup_pkg::SRC_IDX_W-1:0];
    in_sample    = sample[bup_pkg::SAMPLE_W-1:0];
    in_out_row   = out_row[bup_pkg::OUT_IDX_W-1:0];
    in_out_col   = out_col[bup_pkg::OUT_IDX_W-1:0];
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    pixels.note_request(op, src_row, src_col, sample, out_row, out_col);
    @(negedge clk);
    // A gap of random length lets the next request land at any point of
    // the block's busy window, including right as busy falls.
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(40, 1)) @(negedge clk);
    end
  endtask

  task automatic load_sample(input int unsigned row, input int unsigned col,
                             input int unsigned sample);
    send_request(bup_pkg::OP_LOAD, row, col, sample, $urandom_range(PIX_N - 1),
                 $urandom_range(PIX_N - 1));
    loaded[row*SRC_N + col] = 1'b1;
  endtask

  // Every query is a well-formed sequence: any neighbour that has never been
  // written gets a load first, then the query itself goes out.
  task automatic query_pixel(input int unsigned out_row, input int unsigned out_col);
    int unsigned rl, rh, rf, cl, ch, cf;
    pixels.map_axis(out_row, rl, rh, rf);
    pixels.map_axis(out_col, cl, ch, cf);
    if (!loaded[rl*SRC_N + cl]) load_sample(rl, cl, pick_sample());
    if (!loaded[rh*SRC_N + cl]) load_sample(rh, cl, pick_sample());
    if (!loaded[rl*SRC_N + ch]) load_sample(rl, ch, pick_sample());
    if (!loaded[rh*SRC_N + ch]) load_sample(rh, ch, pick_sample());
    send_request(bup_pkg::OP_QUERY, $urandom_range(SRC_N - 1), $urandom_range(SRC_N - 1),
                 $urandom_range(SAMPLE_MAX), out_row, out_col);
  endtask

  initial begin
    int pct_by_phase [4];
    pixels = new();
    pct_by_phase = '{0, 72, 6, 0};
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = bup_pkg::OP_LOAD;
    in_src_row   = '0;
    in_src_col   = '0;
    in_sample    = '0;
    in_out_row   = '0;
    in_out_col   = '0;
    cycles       = 0;
    idle_pct     = 0;

    // Synchronous reset held low while the clock runs, released at a falling
    // edge so that the first request is presented cleanly.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A checkerboard of full-scale and zero samples in the
    // top-left corner exercises the exact-grid case and a mixed blend.
    load_sample(0, 0, SAMPLE_MAX);
    load_sample(0, 1, 0);
    load_sample(1, 0, 0);
    load_sample(1, 1, SAMPLE_MAX);
    query_pixel(0, 0);
    query_pixel(1, 1);
    query_pixel(4, 4);
    query_pixel(8, 8);
    query_pixel(0, 8);
    // Far corner: the upper neighbour is clamped to the last row and column
    // and carries zero weight.
    load_sample(SRC_N - 1, SRC_N - 1, SAMPLE_MAX);
    query_pixel(PIX_N - 1, PIX_N - 1);
    query_pixel(PIX_N - 2, PIX_N - 2);
    query_pixel(PIX_N - 1, 0);
    query_pixel(0, PIX_N - 1);
    query_pixel(PIX_N - 1, PIX_N - 2);
    // A cell whose four neighbours all hold the largest sample must give it
    // back exactly, with no rounding overflow.
    load_sample(7, 7, SAMPLE_MAX);
    load_sample(7, 8, SAMPLE_MAX);
    load_sample(8, 7, SAMPLE_MAX);
    load_sample(8, 8, SAMPLE_MAX);
    query_pixel(63, 63);
    query_pixel(64, 60);
    // Overwrite one entry and read it back through a blend.
    load_sample(8, 8, 0);
    query_pixel(64, 64);
    query_pixel(85, 42);

    // Random part, spread over several idling phases. Queries dominate, and
    // the loads in between keep rewriting the store with fresh values.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = pct_by_phase[phase];
      for (int n = 0; n < RANDOM_REQUESTS / 4; n++) begin
        if ($urandom_range(99) < 35)
          load_sample($urandom_range(SRC_N - 1), $urandom_range(SRC_N - 1),
                      pick_sample());
        else
          query_pixel($urandom_range(PIX_N - 1), $urandom_range(PIX_N - 1));
      end
    end
    start = 1'b0;

    // Drain the outstanding query, then give a stray strobe time to show up.
    while (pixels.pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (pixels.mismatches == 0 && pixels.pending_pixels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/bup_pkg.sv
design/bup_store.sv
design/bup_div.sv
design/bup_mac.sv
design/bilinear_upscale_16_to_128_top.sv
tb/sv/testbench.sv
